/* rtl/bmprle_pkg.sv */
// Shared types and constants for the BMP RLE4/RLE8 stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package bmprle_pkg;

  localparam int unsigned COORD_W = 13;
  localparam logic [COORD_W-1:0] COORD_MAX = '1;

  // Largest image side honored by the outside-image check
  localparam int unsigned MAX_SIDE = 4096;
  // Compare width: a saturated column plus a full run must not wrap
  localparam int unsigned SIDE_W   = COORD_W + 1;

  localparam logic [7:0] NIB_HI_MASK = 8'hf0;
  localparam logic [7:0] NIB_LO_MASK = 8'h0f;

  // Escape codes following a zero count byte
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  // Result event kinds
  localparam logic [1:0] EV_RUN = 2'd0;
  localparam logic [1:0] EV_EOL = 2'd1;
  localparam logic [1:0] EV_EOB = 2'd2;

  typedef enum logic [5:0] {
    PH_COUNT = 6'b000001,
    PH_COLOR = 6'b000010,
    PH_ESC   = 6'b000100,
    PH_DX    = 6'b001000,
    PH_DY    = 6'b010000,
    PH_ABS   = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [7:0]         held_count;
    logic [7:0]         abs_left;
    logic               pad_pending;
    logic [7:0]         held_dx;
  } state_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] row_y;
    logic [7:0]         run_length;
    logic [7:0]         color_even;
    logic [7:0]         color_odd;
    logic               outside_image;
  } result_t;

endpackage

`default_nettype wire

/* rtl/bmprle_step.sv */
// Per-byte parse step: next decoder state and the optional result item.
`timescale 1ns / 1ps
`default_nettype none

module bmprle_step (
  input  bmprle_pkg::state_t                   cur,
  input  logic [7:0]                           data_byte,
  input  logic                                 four_bit_mode,
  input  logic [bmprle_pkg::COORD_W-1:0]       image_width,
  input  logic [bmprle_pkg::COORD_W-1:0]       image_height,
  output bmprle_pkg::state_t                   nxt,
  output logic                                 has_result,
  output bmprle_pkg::result_t                  res
);
  import bmprle_pkg::*;

  function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] a,
                                                 input logic [7:0] b);
    logic [COORD_W:0] s;
    s = {1'b0, a} + {{(COORD_W - 7){1'b0}}, b};
    return s[COORD_W] ? COORD_MAX : s[COORD_W-1:0];
  endfunction

  logic [7:0]        hi_nib;
  logic [7:0]        lo_nib;
  logic              emit_run;
  logic [7:0]        run_len;
  logic [7:0]        run_ce;
  logic [7:0]        run_co;
  logic              two_pix;
  logic [7:0]        left_dec;
  logic [SIDE_W-1:0] w_clamp;
  logic [SIDE_W-1:0] h_clamp;
  logic [SIDE_W-1:0] run_end;
  logic              outside;

  assign hi_nib = (data_byte & NIB_HI_MASK) >> 4;
  assign lo_nib = data_byte & NIB_LO_MASK;
  assign two_pix = four_bit_mode && (cur.abs_left >= 8'd2);
  assign left_dec = cur.abs_left - (two_pix ? 8'd2 : 8'd1);

  // Sizes above the supported side behave as the supported side
  assign w_clamp = ({{(SIDE_W - COORD_W){1'b0}}, image_width} > SIDE_W'(MAX_SIDE))
                   ? SIDE_W'(MAX_SIDE) : SIDE_W'(image_width);
  assign h_clamp = ({{(SIDE_W - COORD_W){1'b0}}, image_height} > SIDE_W'(MAX_SIDE))
                   ? SIDE_W'(MAX_SIDE) : SIDE_W'(image_height);
  assign run_end = SIDE_W'(cur.column) + SIDE_W'(run_len);
  assign outside = (SIDE_W'(cur.row) >= h_clamp) || (run_end > w_clamp);

  always_comb begin
    nxt        = cur;
    has_result = 1'b0;
    emit_run   = 1'b0;
    run_len    = 8'd0;
    run_ce     = 8'd0;
    run_co     = 8'd0;
    res        = '0;
    res.start_x = cur.column;
    res.row_y   = cur.row;

    unique case (cur.phase)
      PH_COLOR: begin
        nxt.phase = PH_COUNT;
        emit_run  = 1'b1;
        run_len   = cur.held_count;
        run_ce    = four_bit_mode ? hi_nib : data_byte;
        run_co    = four_bit_mode ? lo_nib : data_byte;
      end
      PH_ESC: begin
        nxt.phase = PH_COUNT;
        unique case (data_byte)
          ESC_EOL: begin
            has_result     = 1'b1;
            res.event_kind = EV_EOL;
            nxt.column     = '0;
            nxt.row        = sat_add(cur.row, 8'd1);
          end
          ESC_EOB: begin
            has_result     = 1'b1;
            res.event_kind = EV_EOB;
            nxt.column     = '0;
            nxt.row        = '0;
          end
          ESC_DELTA: begin
            nxt.phase = PH_DX;
          end
          default: begin
            nxt.phase       = PH_ABS;
            nxt.abs_left    = data_byte;
            // word padding: odd number of data bytes in the run
            nxt.pad_pending = four_bit_mode ? (data_byte[1] ^ data_byte[0])
                                            : data_byte[0];
          end
        endcase
      end
      PH_DX: begin
        nxt.held_dx = data_byte;
        nxt.phase   = PH_DY;
      end
      PH_DY: begin
        nxt.column = sat_add(cur.column, cur.held_dx);
        nxt.row    = sat_add(cur.row, data_byte);
        nxt.phase  = PH_COUNT;
      end
      PH_ABS: begin
        if (cur.abs_left == 8'd0) begin
          // pad byte, dropped
          nxt.pad_pending = 1'b0;
          nxt.phase       = PH_COUNT;
        end else begin
          emit_run     = 1'b1;
          run_len      = two_pix ? 8'd2 : 8'd1;
          run_ce       = four_bit_mode ? hi_nib : data_byte;
          run_co       = four_bit_mode ? (two_pix ? lo_nib : hi_nib) : data_byte;
          nxt.abs_left = left_dec;
          if (left_dec == 8'd0 && !cur.pad_pending) begin
            nxt.phase = PH_COUNT;
          end
        end
      end
      default: begin
        if (data_byte == 8'd0) begin
          nxt.phase = PH_ESC;
        end else begin
          nxt.held_count = data_byte;
          nxt.phase      = PH_COLOR;
        end
      end
    endcase

    if (emit_run) begin
      has_result        = 1'b1;
      res.event_kind    = EV_RUN;
      res.run_length    = run_len;
      res.color_even    = run_ce;
      res.color_odd     = run_co;
      res.outside_image = outside;
      nxt.column        = sat_add(cur.column, run_len);
    end
  end

endmodule

`default_nettype wire

/* rtl/bmp_rle_stream_decoder.sv */
// Top level of the BMP RLE4/RLE8 stream decoder: state, config and output buffer.
// Results are registered: each result item is held in the output buffer before it reaches the output.
// Throughput: one byte per cycle while in_stall is low; the parse step is a single combinational pass.
// A two-entry output buffer (result register plus skid) keeps input flowing
// after the output stalls until a result lands in the skid; in_stall is the skid-full flag.
// Synchronous active-low reset clears parse state, position and valid flags; config resets to RLE8, MAX_SIDE sides.
`timescale 1ns / 1ps
`default_nettype none

module bmp_rle_stream_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_data_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_event_kind,
  output logic [bmprle_pkg::COORD_W-1:0]   out_start_x,
  output logic [bmprle_pkg::COORD_W-1:0]   out_row_y,
  output logic [7:0]                       out_run_length,
  output logic [7:0]                       out_color_even,
  output logic [7:0]                       out_color_odd,
  output logic                             out_outside_image,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [bmprle_pkg::COORD_W-1:0]   cfg_data
);
  import bmprle_pkg::*;

  logic               four_bit_mode_r;
  logic [COORD_W-1:0] image_width_r;
  logic [COORD_W-1:0] image_height_r;

  state_t  state_r;
  state_t  state_nxt;
  logic    has_result;
  result_t res;

  logic    out_valid_r;
  result_t out_r;
  logic    skid_valid_r;
  result_t skid_r;

  logic    in_accept;
  logic    res_valid;
  logic    out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign res_valid = in_accept && has_result;
  assign out_free  = !out_valid_r || !out_stall;

  bmprle_step u_step (
    .cur           (state_r),
    .data_byte     (in_data_byte),
    .four_bit_mode (four_bit_mode_r),
    .image_width   (image_width_r),
    .image_height  (image_height_r),
    .nxt           (state_nxt),
    .has_result    (has_result),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_bit_mode_r <= 1'b0;
      image_width_r   <= COORD_W'(MAX_SIDE);
      image_height_r  <= COORD_W'(MAX_SIDE);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:   four_bit_mode_r <= cfg_data[0];
        CFG_WIDTH:  image_width_r   <= cfg_data;
        CFG_HEIGHT: image_height_r  <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_COUNT, default: '0};
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // Output buffer: result register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res;
    end
    if (!out_free && res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_kind    = out_r.event_kind;
  assign out_start_x       = out_r.start_x;
  assign out_row_y         = out_r.row_y;
  assign out_run_length    = out_r.run_length;
  assign out_color_even    = out_r.color_even;
  assign out_color_odd     = out_r.color_odd;
  assign out_outside_image = out_r.outside_image;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while result register empty");

  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.event_kind == EV_RUN |-> out_r.run_length != 8'd0)
    else $error("pixel run item with zero length");

  a_event_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.event_kind != EV_RUN
      |-> out_r.run_length == 8'd0 && !out_r.outside_image)
    else $error("line or bitmap event carries run data");

  a_abs_pad: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_ABS && state_r.abs_left == 8'd0 |-> state_r.pad_pending)
    else $error("absolute mode exhausted without a pending pad byte");

endmodule

`default_nettype wire
